// ----- rtl/core/bql_pkg.sv -----
package bql_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned DELAY_W  = 48;
  localparam int unsigned AXES     = 3;
  localparam int unsigned AX_W     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // delays are split in halves so every product stays near 32x32
  localparam int unsigned HALF_W   = DELAY_W / 2;
  localparam int unsigned MA_W     = ((SAMPLE_W > HALF_W) ? SAMPLE_W : HALF_W) + 1;
  localparam int unsigned MB_W     = COEF_W + 1;
  localparam int unsigned PROD_W   = MA_W + MB_W;
  localparam int unsigned ACC_FRAC = 40;
  localparam int unsigned W0_SHIFT = 28;
  localparam int unsigned ACC_W    = DELAY_W + COEF_W + 4;

  localparam int unsigned PC_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A1     = 3'd0,
    CFG_A2     = 3'd1,
    CFG_B0     = 3'd2,
    CFG_B1     = 3'd3,
    CFG_B2     = 3'd4,
    CFG_GAIN   = 3'd5,
    CFG_BYPASS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_x;
    logic signed [SAMPLE_W-1:0] filtered_y;
    logic signed [SAMPLE_W-1:0] filtered_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic        [COEF_W-1:0] gain;
  } coef_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LOAD_X,
    ACC_LOAD_P,
    ACC_CLEAR,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    MA_NONE,
    MA_X,
    MA_D1L,
    MA_D1H,
    MA_D2L,
    MA_D2H,
    MA_W0L,
    MA_W0H
  } ma_sel_e;

  typedef enum logic [2:0] {
    MB_GAIN,
    MB_A1,
    MB_A2,
    MB_B0,
    MB_B1,
    MB_B2
  } mb_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_W0,
    WR_PRELOAD,
    WR_RESULT
  } wr_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_AXIS,
    JMP_WAIT
  } jmp_e;

  typedef struct packed {
    acc_op_e         acc_op;
    logic            shift_hi;
    ma_sel_e         ma;
    mb_sel_e         mb;
    wr_e             wr;
    jmp_e            jmp;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  typedef struct packed {
    ucw_t            uc;
    logic [AX_W-1:0] ax;
    logic            start;
    logic            bypass;
    logic            ld_out;
  } seq_ctl_t;

  // program entry points
  localparam logic [PC_W-1:0] PC_PRE  = 5'd0;
  localparam logic [PC_W-1:0] PC_FLT  = 5'd3;
  localparam logic [PC_W-1:0] PC_DONE = 5'd17;

  function automatic ucw_t mk(input acc_op_e op, input logic sh, input ma_sel_e ma,
                              input mb_sel_e mb, input wr_e wr, input jmp_e jmp,
                              input logic [PC_W-1:0] tgt);
    ucw_t w;
    w.acc_op   = op;
    w.shift_hi = sh;
    w.ma       = ma;
    w.mb       = mb;
    w.wr       = wr;
    w.jmp      = jmp;
    w.tgt      = tgt;
    return w;
  endfunction

  // accumulate fields act on the product issued by the previous step
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      // preload: delays <- sat(x * init_gain)
      5'd0:  w = mk(ACC_NOP,    1'b0, MA_X,    MB_GAIN, WR_NONE,    JMP_NEXT, PC_PRE);
      5'd1:  w = mk(ACC_LOAD_P, 1'b0, MA_NONE, MB_GAIN, WR_NONE,    JMP_NEXT, PC_PRE);
      5'd2:  w = mk(ACC_NOP,    1'b0, MA_NONE, MB_GAIN, WR_PRELOAD, JMP_AXIS, PC_PRE);
      // w0 = x - a1*w1 - a2*w2
      5'd3:  w = mk(ACC_LOAD_X, 1'b0, MA_D1L,  MB_A1,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd4:  w = mk(ACC_SUB,    1'b0, MA_D1H,  MB_A1,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd5:  w = mk(ACC_SUB,    1'b1, MA_D2L,  MB_A2,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd6:  w = mk(ACC_SUB,    1'b0, MA_D2H,  MB_A2,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd7:  w = mk(ACC_SUB,    1'b1, MA_NONE, MB_A2,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd8:  w = mk(ACC_CLEAR,  1'b0, MA_NONE, MB_A2,   WR_W0,      JMP_NEXT, PC_FLT);
      // y = b0*w0 + b1*w1 + b2*w2
      5'd9:  w = mk(ACC_NOP,    1'b0, MA_W0L,  MB_B0,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd10: w = mk(ACC_ADD,    1'b0, MA_W0H,  MB_B0,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd11: w = mk(ACC_ADD,    1'b1, MA_D1L,  MB_B1,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd12: w = mk(ACC_ADD,    1'b0, MA_D1H,  MB_B1,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd13: w = mk(ACC_ADD,    1'b1, MA_D2L,  MB_B2,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd14: w = mk(ACC_ADD,    1'b0, MA_D2H,  MB_B2,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd15: w = mk(ACC_ADD,    1'b1, MA_NONE, MB_B2,   WR_NONE,    JMP_NEXT, PC_FLT);
      5'd16: w = mk(ACC_NOP,    1'b0, MA_NONE, MB_B2,   WR_RESULT,  JMP_AXIS, PC_FLT);
      // hand the item to the output register
      5'd17: w = mk(ACC_NOP,    1'b0, MA_NONE, MB_GAIN, WR_NONE,    JMP_WAIT, PC_DONE);
      default: w = mk(ACC_NOP,  1'b0, MA_NONE, MB_GAIN, WR_NONE,    JMP_WAIT, PC_DONE);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/bql_seq.sv -----
module bql_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 bypass_i,
  input  logic                 restart_i,
  input  logic                 out_free_i,
  output logic                 busy_o,
  output bql_pkg::seq_ctl_t    ctl_o
);

  logic                         busy_q, busy_d;
  logic                         primed_q, primed_d;
  logic [bql_pkg::PC_W-1:0]     pc_q, pc_d;
  logic [bql_pkg::AX_W-1:0]     ax_q, ax_d;
  bql_pkg::ucw_t                uc;
  logic                         last_ax;
  logic                         ld_out;

  assign uc      = bql_pkg::ucode(pc_q);
  assign last_ax = (ax_q == bql_pkg::AX_W'(bql_pkg::AXES - 1));
  assign ld_out  = busy_q && (uc.jmp == bql_pkg::JMP_WAIT) && out_free_i;

  always_comb begin
    busy_d   = busy_q;
    primed_d = primed_q;
    pc_d     = pc_q;
    ax_d     = ax_q;
    if (start_i) begin
      busy_d = 1'b1;
      ax_d   = '0;
      if (bypass_i) begin
        pc_d     = bql_pkg::PC_DONE;
        primed_d = primed_q && !restart_i;
      end else begin
        pc_d     = (restart_i || !primed_q) ? bql_pkg::PC_PRE : bql_pkg::PC_FLT;
        primed_d = 1'b1;
      end
    end else if (busy_q) begin
      case (uc.jmp)
        bql_pkg::JMP_NEXT: begin
          pc_d = pc_q + 1'b1;
        end
        bql_pkg::JMP_AXIS: begin
          if (last_ax) begin
            ax_d = '0;
            pc_d = pc_q + 1'b1;
          end else begin
            ax_d = ax_q + 1'b1;
            pc_d = uc.tgt;
          end
        end
        bql_pkg::JMP_WAIT: begin
          if (out_free_i) begin
            busy_d = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      primed_q <= 1'b0;
      pc_q     <= bql_pkg::PC_DONE;
      ax_q     <= '0;
    end else begin
      busy_q   <= busy_d;
      primed_q <= primed_d;
      pc_q     <= pc_d;
      ax_q     <= ax_d;
    end
  end

  assign busy_o        = busy_q;
  assign ctl_o.uc      = busy_q ? uc : bql_pkg::ucode(bql_pkg::PC_DONE);
  assign ctl_o.ax      = ax_q;
  assign ctl_o.start   = start_i;
  assign ctl_o.bypass  = bypass_i;
  assign ctl_o.ld_out  = ld_out;

endmodule

// ----- rtl/core/bql_dp.sv -----
module bql_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bql_pkg::seq_ctl_t    ctl_i,
  input  bql_pkg::coef_t       coef_i,
  input  bql_pkg::in_item_t    item_i,
  output bql_pkg::out_item_t   res_o
);

  localparam int unsigned SW = bql_pkg::SAMPLE_W;
  localparam int unsigned DW = bql_pkg::DELAY_W;
  localparam int unsigned HW = bql_pkg::HALF_W;
  localparam int unsigned AW = bql_pkg::ACC_W;
  localparam int unsigned PW = bql_pkg::PROD_W;

  logic signed [SW-1:0]          x_q   [bql_pkg::AXES];
  logic signed [SW-1:0]          res_q [bql_pkg::AXES];
  logic signed [DW-1:0]          d1_q  [bql_pkg::AXES];
  logic signed [DW-1:0]          d2_q  [bql_pkg::AXES];
  logic signed [DW-1:0]          w0_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [AW-1:0]          acc_q, acc_d;

  logic signed [SW-1:0]          x_sel;
  logic signed [DW-1:0]          d1_sel, d2_sel;
  logic signed [bql_pkg::MA_W-1:0] ma;
  logic signed [bql_pkg::MB_W-1:0] mb;
  logic signed [PW-1:0]          prod_d;
  logic signed [AW-1:0]          p_ext, p_sh, x_ext;
  logic signed [AW-1:0]          half, rsum, rsh;
  logic signed [DW-1:0]          sat_d;
  logic signed [SW-1:0]          sat_s;
  logic                          ovf_d, ovf_s;

  assign x_sel  = x_q[ctl_i.ax];
  assign d1_sel = d1_q[ctl_i.ax];
  assign d2_sel = d2_q[ctl_i.ax];

  function automatic logic signed [bql_pkg::MA_W-1:0] lo_half(input logic [DW-1:0] v);
    return bql_pkg::MA_W'({1'b0, v[HW-1:0]});
  endfunction

  function automatic logic signed [bql_pkg::MA_W-1:0] hi_half(input logic [DW-1:0] v);
    return bql_pkg::MA_W'($signed(v[DW-1:HW]));
  endfunction

  // operand selection and multiplier
  always_comb begin
    case (ctl_i.uc.ma)
      bql_pkg::MA_X:   ma = bql_pkg::MA_W'(x_sel);
      bql_pkg::MA_D1L: ma = lo_half(d1_sel);
      bql_pkg::MA_D1H: ma = hi_half(d1_sel);
      bql_pkg::MA_D2L: ma = lo_half(d2_sel);
      bql_pkg::MA_D2H: ma = hi_half(d2_sel);
      bql_pkg::MA_W0L: ma = lo_half(w0_q);
      bql_pkg::MA_W0H: ma = hi_half(w0_q);
      default:         ma = '0;
    endcase
    case (ctl_i.uc.mb)
      bql_pkg::MB_GAIN: mb = $signed({1'b0, coef_i.gain});
      bql_pkg::MB_A1:   mb = bql_pkg::MB_W'(coef_i.a1);
      bql_pkg::MB_A2:   mb = bql_pkg::MB_W'(coef_i.a2);
      bql_pkg::MB_B0:   mb = bql_pkg::MB_W'(coef_i.b0);
      bql_pkg::MB_B1:   mb = bql_pkg::MB_W'(coef_i.b1);
      bql_pkg::MB_B2:   mb = bql_pkg::MB_W'(coef_i.b2);
      default:          mb = '0;
    endcase
    prod_d = PW'(ma) * PW'(mb);
  end

  // accumulator
  always_comb begin
    p_ext = AW'(prod_q);
    p_sh  = ctl_i.uc.shift_hi ? (p_ext <<< HW) : p_ext;
    x_ext = AW'(x_sel) <<< bql_pkg::ACC_FRAC;
    case (ctl_i.uc.acc_op)
      bql_pkg::ACC_LOAD_X: acc_d = x_ext;
      bql_pkg::ACC_LOAD_P: acc_d = p_ext;
      bql_pkg::ACC_CLEAR:  acc_d = '0;
      bql_pkg::ACC_ADD:    acc_d = acc_q + p_sh;
      bql_pkg::ACC_SUB:    acc_d = acc_q - p_sh;
      default:             acc_d = acc_q;
    endcase
  end

  // round half up, shift, saturate
  always_comb begin
    case (ctl_i.uc.wr)
      bql_pkg::WR_W0:     half = AW'(1) <<< (bql_pkg::W0_SHIFT - 1);
      bql_pkg::WR_RESULT: half = AW'(1) <<< (bql_pkg::ACC_FRAC - 1);
      default:            half = '0;
    endcase
    rsum = acc_q + half;
    case (ctl_i.uc.wr)
      bql_pkg::WR_W0:     rsh = rsum >>> bql_pkg::W0_SHIFT;
      bql_pkg::WR_RESULT: rsh = rsum >>> bql_pkg::ACC_FRAC;
      default:            rsh = rsum;
    endcase
    ovf_d = !((&rsh[AW-1:DW-1]) || !(|rsh[AW-1:DW-1]));
    ovf_s = !((&rsh[AW-1:SW-1]) || !(|rsh[AW-1:SW-1]));
    if (ovf_d) begin
      sat_d = rsh[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sat_d = rsh[DW-1:0];
    end
    if (ovf_s) begin
      sat_s = rsh[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_s = rsh[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctl_i.uc.wr == bql_pkg::WR_W0) begin
      w0_q <= sat_d;
    end
    if (ctl_i.start) begin
      x_q[0] <= item_i.sample_x;
      x_q[1] <= item_i.sample_y;
      x_q[2] <= item_i.sample_z;
      if (ctl_i.bypass) begin
        res_q[0] <= item_i.sample_x;
        res_q[1] <= item_i.sample_y;
        res_q[2] <= item_i.sample_z;
      end
    end else if (ctl_i.uc.wr == bql_pkg::WR_RESULT) begin
      res_q[ctl_i.ax] <= sat_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bql_pkg::AXES; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (!ctl_i.start) begin
      case (ctl_i.uc.wr)
        bql_pkg::WR_PRELOAD: begin
          d1_q[ctl_i.ax] <= sat_d;
          d2_q[ctl_i.ax] <= sat_d;
        end
        bql_pkg::WR_RESULT: begin
          d1_q[ctl_i.ax] <= w0_q;
          d2_q[ctl_i.ax] <= d1_sel;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.filtered_x = res_q[0];
  assign res_o.filtered_y = res_q[1];
  assign res_o.filtered_z = res_q[2];

endmodule

// ----- rtl/core/biquad_lowpass_3axis.sv -----
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+---------------------------------------
// input     | in_valid_i   | in_stall_o   | in_item_i  (sample_x/y/z, restart)
// output    | out_valid_o  | out_stall_i  | out_item_o (filtered_x/y/z)
// config    | cfg_we_i     | (none)       | cfg_idx_i, cfg_wdata_i
//
// one item at a time: bypass skips the microcode and goes to the hand-off step; a filtered
// item runs 14 microcode steps per axis on the single 25x33 multiplier, plus one
// hand-off step, with the preload steps for every axis first when the delays are preloaded.
// in_stall_o is high from the accept until the result moves into the output register
// a stalled output holds the finished item; the next item can be accepted meanwhile
// reset is asynchronous, active low; it restores the register defaults (bypass on)
module biquad_lowpass_3axis (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bql_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bql_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [bql_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bql_pkg::CFG_W-1:0]         cfg_wdata_i
);

  // software-visible coefficient registers
  bql_pkg::coef_t      coef_q;
  logic                bypass_q;

  // sequencer and datapath
  bql_pkg::seq_ctl_t   ctl;
  bql_pkg::out_item_t  res;
  logic                busy;
  logic                in_acc;
  logic                out_free;

  // output register
  logic                out_valid_q;
  bql_pkg::out_item_t  out_q;

  assign in_acc   = in_valid_i && !busy;
  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      bypass_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bql_pkg::CFG_A1:     coef_q.a1   <= cfg_wdata_i;
        bql_pkg::CFG_A2:     coef_q.a2   <= cfg_wdata_i;
        bql_pkg::CFG_B0:     coef_q.b0   <= cfg_wdata_i;
        bql_pkg::CFG_B1:     coef_q.b1   <= cfg_wdata_i;
        bql_pkg::CFG_B2:     coef_q.b2   <= cfg_wdata_i;
        bql_pkg::CFG_GAIN:   coef_q.gain <= cfg_wdata_i;
        bql_pkg::CFG_BYPASS: bypass_q    <= cfg_wdata_i[0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  bql_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .bypass_i   (bypass_q),
    .restart_i  (in_item_i.restart),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctl_o      (ctl)
  );

  bql_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .coef_i (coef_q),
    .item_i (in_item_i),
    .res_o  (res)
  );

  // result moves in on the sequencer's hand-off step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_out) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // an accepted item keeps the input stalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // a hand-off never overwrites an item that is still stalled at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ld_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");

  // a hand-off only happens while the sequencer is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ld_out |-> busy)
    else $error("hand-off while idle");

  // the hand-off releases the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ld_out |=> !in_stall_o)
    else $error("sequencer stuck after hand-off");
`endif

endmodule

// ----- dv/biquad_result_checker.sv -----
module biquad_result_checker
  import bql_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          queued_o,
  output int unsigned          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_CAP = 100;

  // shadow copy of the filter registers and state
  logic signed [COEF_W-1:0]  a1_q, a2_q, b0_q, b1_q, b2_q;
  logic        [COEF_W-1:0]  gain_q;
  logic                      bypass_q;
  logic                      primed_q;
  logic signed [DELAY_W-1:0] w1_q [AXES];
  logic signed [DELAY_W-1:0] w2_q [AXES];

  out_item_t filtered_fifo [$];

  function automatic logic signed [127:0] saturate(input logic signed [127:0] v,
                                                   input int unsigned w);
    logic signed [127:0] top_v;
    logic signed [127:0] bot_v;
    top_v = (128'sd1 <<< (w - 1)) - 128'sd1;
    bot_v = -(128'sd1 <<< (w - 1));
    if (v > top_v) return top_v;
    if (v < bot_v) return bot_v;
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= PRINT_CAP) begin
      $display("%t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
  endtask

  // one sample through the three biquads, updating the shadow delays
  task automatic run_biquad(input in_item_t it, output out_item_t res);
    logic signed [SAMPLE_W-1:0] xs [AXES];
    logic signed [SAMPLE_W-1:0] ys [AXES];
    logic signed [127:0]        x, d1, d2, w0, acc;
    logic signed [127:0]        c_a1, c_a2, c_b0, c_b1, c_b2, g;
    xs[0] = $signed(it.sample_x);
    xs[1] = $signed(it.sample_y);
    xs[2] = $signed(it.sample_z);
    c_a1 = a1_q;
    c_a2 = a2_q;
    c_b0 = b0_q;
    c_b1 = b1_q;
    c_b2 = b2_q;
    g    = gain_q;
    if (it.restart) primed_q = 1'b0;
    if (bypass_q) begin
      ys = xs;
    end else begin
      if (!primed_q) begin
        for (int i = 0; i < AXES; i++) begin
          x = xs[i];
          w0 = saturate(x * g, DELAY_W);
          w1_q[i] = w0[DELAY_W-1:0];
          w2_q[i] = w0[DELAY_W-1:0];
        end
        primed_q = 1'b1;
      end
      for (int i = 0; i < AXES; i++) begin
        x  = xs[i];
        d1 = w1_q[i];
        d2 = w2_q[i];
        // 40 fraction bits throughout the sums
        acc = (x <<< ACC_FRAC) - d1 * c_a1 - d2 * c_a2;
        w0  = saturate((acc + (128'sd1 <<< (W0_SHIFT - 1))) >>> W0_SHIFT, DELAY_W);
        acc = w0 * c_b0 + d1 * c_b1 + d2 * c_b2;
        acc = saturate((acc + (128'sd1 <<< (ACC_FRAC - 1))) >>> ACC_FRAC, SAMPLE_W);
        ys[i]   = acc[SAMPLE_W-1:0];
        w2_q[i] = w1_q[i];
        w1_q[i] = w0[DELAY_W-1:0];
      end
    end
    res.filtered_x = ys[0];
    res.filtered_y = ys[1];
    res.filtered_z = ys[2];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t pred;
    if (!rst_ni) begin
      a1_q     = '0;
      a2_q     = '0;
      b0_q     = '0;
      b1_q     = '0;
      b2_q     = '0;
      gain_q   = '0;
      bypass_q = 1'b1;
      primed_q = 1'b0;
      for (int i = 0; i < AXES; i++) begin
        w1_q[i] = '0;
        w2_q[i] = '0;
      end
      filtered_fifo.delete();
      mismatch_cnt_o = 0;
      queued_o       = 0;
      checked_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_A1:     a1_q     = cfg_wdata_i;
          CFG_A2:     a2_q     = cfg_wdata_i;
          CFG_B0:     b0_q     = cfg_wdata_i;
          CFG_B1:     b1_q     = cfg_wdata_i;
          CFG_B2:     b2_q     = cfg_wdata_i;
          CFG_GAIN:   gain_q   = cfg_wdata_i;
          CFG_BYPASS: bypass_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (filtered_fifo.size() == 0) begin
          flag_mismatch("result with no item pending", $signed(out_item_i.filtered_x), 0);
        end else begin
          want = filtered_fifo.pop_front();
          checked_o++;
          if (out_item_i.filtered_x !== want.filtered_x)
            flag_mismatch("filtered_x", $signed(out_item_i.filtered_x),
                          $signed(want.filtered_x));
          if (out_item_i.filtered_y !== want.filtered_y)
            flag_mismatch("filtered_y", $signed(out_item_i.filtered_y),
                          $signed(want.filtered_y));
          if (out_item_i.filtered_z !== want.filtered_z)
            flag_mismatch("filtered_z", $signed(out_item_i.filtered_z),
                          $signed(want.filtered_z));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        run_biquad(in_item_i, pred);
        filtered_fifo.push_back(pred);
      end
      queued_o = filtered_fifo.size();
    end
  end

endmodule

// ----- dv/tb_biquad_lowpass_3axis.sv -----
module tb_biquad_lowpass_3axis;
  timeunit 1ns;
  timeprecision 1ps;
  import bql_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 244;
  localparam int unsigned SETTLE_CYCLES = 8;
  // longest path is the preload plus filter
  localparam int unsigned DRAIN_CYCLES = 60;

  localparam int S_HI = 2 ** (SAMPLE_W - 1) - 1;
  localparam int S_LO = -(2 ** (SAMPLE_W - 1));

  // no register behind this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // butterworth at a tenth of the sample rate, q3.28, gain q20.12
  localparam logic signed [COEF_W-1:0] BW_A1   = -32'sd306816492;
  localparam logic signed [COEF_W-1:0] BW_A2   = 32'sd110810585;
  localparam logic signed [COEF_W-1:0] BW_B0   = 32'sd18107430;
  localparam logic signed [COEF_W-1:0] BW_B1   = 32'sd36214860;
  localparam logic        [COEF_W-1:0] BW_GAIN = 32'd15180;
  localparam logic        [COEF_W-1:0] C_MAX   = 32'h7FFF_FFFF;
  localparam logic        [COEF_W-1:0] C_MIN   = 32'h8000_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int unsigned mismatches;
  int unsigned queued;
  int unsigned checked;

  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned restarts   = 0;
  int unsigned settings   = 0;

  // when set, both sides run without gaps or stalls
  bit quiet = 1'b0;

  biquad_lowpass_3axis i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  biquad_result_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_item_i     (out_item),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatches),
    .queued_o       (queued),
    .checked_o      (checked)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding", cycles, queued);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_item_t item(input int x, input int y, input int z, input bit r);
    in_item_t it;
    it.sample_x = x[SAMPLE_W-1:0];
    it.sample_y = y[SAMPLE_W-1:0];
    it.sample_z = z[SAMPLE_W-1:0];
    it.restart  = r;
    return it;
  endfunction

  // a fresh signal level: rails, near zero, or anywhere
  function automatic int pick_level();
    logic [31:0] raw;
    case ($urandom_range(0, 7))
      0: return S_HI;
      1: return S_LO;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: begin
        raw = $urandom();
        return $signed(raw[SAMPLE_W-1:0]);
      end
    endcase
  endfunction

  // a sample close to a held level, clipped to the sample range
  function automatic int near(input int level);
    int v;
    v = level + int'($urandom_range(0, 127)) - 64;
    if (v > S_HI) v = S_HI;
    if (v < S_LO) v = S_LO;
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // output side: a random hold before each result is taken
  initial begin : result_side
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = quiet ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // offer one item after a random gap and hold it until taken
  task automatic send(input in_item_t it);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (it.restart) restarts++;
  endtask

  // drop valid and wait until every result is back, then a few idle cycles
  task automatic settle(input int unsigned extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (queued != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  // back to back writes of every register, plus the unused index
  task automatic load_setting(input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                              input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                              input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] gain,
                              input bit byp);
    logic [CFG_W-1:0] bdat;
    bdat    = $urandom();
    bdat[0] = byp;
    write_reg(CFG_UNUSED, $urandom());
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_B0, b0);
    write_reg(CFG_B1, b1);
    write_reg(CFG_B2, b2);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_BYPASS, bdat);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    in_item_t         it;
    int               levels [AXES];
    int               v;
    logic [COEF_W-1:0] ca1, ca2, cb0, cb1, cb2, cg;
    bit               byp;

    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // register defaults: bypass on, samples pass straight through
    send(item(S_HI, S_LO, 0, 1'b0));
    send(item(S_LO, S_HI, -1, 1'b1));
    send(item(1, -1, 0, 1'b0));
    send(item(0, 0, 0, 1'b1));

    // stock low-pass; first item preloads the delays
    settle(SETTLE_CYCLES);
    load_setting(BW_A1, BW_A2, BW_B0, BW_B1, BW_B0, BW_GAIN, 1'b0);
    send(item(1000, -1000, 0, 1'b0));
    send(item(1000, -1000, 0, 1'b0));
    send(item(S_HI, S_LO, 0, 1'b0));
    send(item(S_HI, S_LO, 1, 1'b0));
    send(item(S_LO, S_HI, -1, 1'b0));
    send(item(0, 0, 0, 1'b1));
    send(item(S_HI, S_HI, S_HI, 1'b1));
    send(item(S_LO, S_LO, S_LO, 1'b0));

    // coefficient and gain rails drive delays and outputs into saturation
    settle(SETTLE_CYCLES);
    load_setting(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, '1, 1'b0);
    send(item(S_HI, S_LO, 12345, 1'b1));
    send(item(S_HI, S_LO, -12345, 1'b0));
    send(item(S_LO, S_HI, 0, 1'b0));
    send(item(S_HI, S_HI, S_HI, 1'b0));
    send(item(S_LO, S_LO, S_LO, 1'b1));
    send(item(-1, 1, 0, 1'b0));

    // restart under bypass still forces a preload once bypass is off
    settle(SETTLE_CYCLES);
    load_setting(BW_A1, BW_A2, BW_B0, BW_B1, BW_B0, BW_GAIN, 1'b1);
    send(item(500, 600, 700, 1'b1));
    settle(SETTLE_CYCLES);
    load_setting(BW_A1, BW_A2, BW_B0, BW_B1, BW_B0, BW_GAIN, 1'b0);
    send(item(-500, -600, -700, 1'b0));
    send(item(-500, -600, -700, 1'b0));

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle(SETTLE_CYCLES);
      case ($urandom_range(0, 3))
        0: begin
          // stock filter, slightly detuned
          ca1 = BW_A1 + int'($urandom_range(0, 4095)) - 2048;
          ca2 = BW_A2 + int'($urandom_range(0, 4095)) - 2048;
          cb0 = BW_B0 + int'($urandom_range(0, 255)) - 128;
          cb1 = BW_B1 + int'($urandom_range(0, 255)) - 128;
          cb2 = BW_B0 + int'($urandom_range(0, 255)) - 128;
          cg  = BW_GAIN + int'($urandom_range(0, 63)) - 32;
        end
        1: begin
          ca1 = $urandom();
          ca2 = $urandom();
          cb0 = $urandom();
          cb1 = $urandom();
          cb2 = $urandom();
          cg  = $urandom();
        end
        2: begin
          // moderate coefficients within two units
          v = int'($urandom_range(0, 1 << 30)) - (1 << 29);
          ca1 = v;
          v = int'($urandom_range(0, 1 << 28)) - (1 << 27);
          ca2 = v;
          cb0 = $urandom_range(0, 1 << 26);
          cb1 = $urandom_range(0, 1 << 27);
          cb2 = $urandom_range(0, 1 << 26);
          cg  = $urandom_range(0, 65535);
        end
        default: begin
          ca1 = pick_coef();
          ca2 = pick_coef();
          cb0 = pick_coef();
          cb1 = pick_coef();
          cb2 = pick_coef();
          cg  = pick_coef();
        end
      endcase
      byp = ($urandom_range(0, 5) == 0);
      load_setting(ca1, ca2, cb0, cb1, cb2, cg, byp);

      for (int a = 0; a < AXES; a++) levels[a] = pick_level();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        if ($urandom_range(0, 4) == 0) begin
          // unrelated samples on every axis
          it = item(pick_level(), pick_level(), pick_level(), 1'b0);
        end else begin
          // held levels with small noise and occasional steps
          for (int a = 0; a < AXES; a++) begin
            if ($urandom_range(0, 15) == 0) levels[a] = pick_level();
          end
          it = item(near(levels[0]), near(levels[1]), near(levels[2]), 1'b0);
        end
        it.restart = ($urandom_range(0, 24) == 0);
        send(it);
      end
    end

    quiet = 1'b0;
    settle(DRAIN_CYCLES);
    $display("covered %0d items under %0d register settings, %0d of them with restart",
             items_sent, settings, restarts);
    $display("checked %0d results, %0d mismatches, %0d outstanding",
             checked, mismatches, queued);
    if (mismatches == 0 && queued == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
